@@ design/oale_pkg.sv @@
// shared types and constants of the ordered array list engine
package oale_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ENTRY_W      = 32;
    localparam int FUNC_W       = 4;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 5;

    typedef logic signed [ENTRY_W-1:0] t_entry;

    typedef enum logic [FUNC_W-1:0] {
        F_INS_AT    = 4'd0,
        F_INS_FIRST = 4'd1,
        F_INS_LAST  = 4'd2,
        F_DEL_AT    = 4'd3,
        F_DEL_KEY   = 4'd4,
        F_REP_AT    = 4'd5,
        F_READ_AT   = 4'd6,
        F_SEARCH    = 4'd7,
        F_CLEAR     = 4'd8
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOKEY  = 2'd3
    } t_status;

    // per-cell command broadcast from the controller
    typedef struct packed {
        logic cmp;   // compare held entry against the key
        logic load;  // take the new value
        logic up;    // take the left neighbor's entry
        logic down;  // take the right neighbor's entry
    } t_cell_cmd;

endpackage

@@ design/ordered_array_list_engine_core.sv @@
// top level of the ordered array list engine: controller over a chain of cells
// an accepted item waits in execute until the result register is free or draining,
// then the chain updates and the result is registered; a new item is taken only
// from idle; the key compare in all cells runs in the accept cycle and the shift /
// load of the cell chain runs in the execute cycle
// reset: i_rst_n synchronous active low clears the count, controller and output
// valid; cell entries are not reset and are only read after being written
module ordered_array_list_engine_core #(
    parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [oale_pkg::FUNC_W-1:0]    i_func,
    input  logic [oale_pkg::POS_W-1:0]     i_pos,
    input  logic signed [oale_pkg::ENTRY_W-1:0] i_value,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [oale_pkg::ENTRY_W-1:0] o_read_value,
    output logic                           o_found,
    output logic [oale_pkg::STATUS_W-1:0]  o_status,
    output logic [oale_pkg::LEN_W-1:0]     o_length
);
    import oale_pkg::*;

    // count width holds 0..CAPACITY, compare width covers both pos and count
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [FUNC_W-1:0]     r_func;
    logic [POS_W-1:0]      r_pos;
    t_entry                r_value;

    logic                  r_out_valid;
    t_entry                r_out_read_value;
    logic                  r_out_found;
    t_status               r_out_status;
    logic [LEN_W-1:0]      r_out_length;

    logic                  in_accept;
    logic                  exec_go;

    t_cell_cmd             cell_cmd   [CAPACITY];
    t_entry                cell_entry [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;

    // key match over live entries, first hit and the cells at or after it
    logic [CAPACITY-1:0]   live_match;
    logic [CAPACITY-1:0]   first_hit;
    logic [CAPACITY-1:0]   from_hit;
    logic                  key_hit;

    logic [CMP_W-1:0]      pos_w;
    logic [CMP_W-1:0]      cnt_w;
    logic [CMP_W-1:0]      ins_at;
    logic                  full;
    t_entry                sel_entry;

    // decoded operation, valid in the execute cycle
    logic                  do_ins;
    logic                  do_del_pos;
    logic                  do_del_key;
    logic                  do_rep;
    logic [CNT_W-1:0]      n_count;
    t_entry                n_read_value;
    logic                  n_found;
    t_status               n_status;

    assign in_accept = i_in_valid && o_in_ready;
    // result register must be free (or draining) before the chain updates
    assign exec_go   = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign pos_w     = CMP_W'(r_pos);
    assign cnt_w     = CMP_W'(r_count);
    assign full      = (r_count == CNT_W'(CAPACITY));
    assign sel_entry = cell_entry[pos_w[IDX_W-1:0]];

    assign first_hit = live_match & (~live_match + CAPACITY'(1));
    // all ones from the first hit upward; zero when there is no hit
    assign from_hit  = ~(first_hit - CAPACITY'(1));
    assign key_hit   = |live_match;

    // operation decode and status
    always_comb begin
        do_ins       = 1'b0;
        do_del_pos   = 1'b0;
        do_del_key   = 1'b0;
        do_rep       = 1'b0;
        ins_at       = '0;
        n_count      = r_count;
        n_read_value = '0;
        n_found      = 1'b0;
        n_status     = ST_OK;
        case (r_func)
            F_INS_AT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (pos_w > cnt_w) begin
                    n_status = ST_BADPOS;
                end else begin
                    do_ins  = 1'b1;
                    ins_at  = pos_w;
                    n_count = r_count + CNT_W'(1);
                end
            end
            F_INS_FIRST: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    ins_at  = '0;
                    n_count = r_count + CNT_W'(1);
                end
            end
            F_INS_LAST: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    ins_at  = cnt_w;
                    n_count = r_count + CNT_W'(1);
                end
            end
            F_DEL_AT: begin
                if (pos_w >= cnt_w) begin
                    n_status = ST_BADPOS;
                end else begin
                    do_del_pos   = 1'b1;
                    n_read_value = sel_entry;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            F_DEL_KEY: begin
                if (key_hit) begin
                    // the removed entry equals the key
                    do_del_key   = 1'b1;
                    n_found      = 1'b1;
                    n_read_value = r_value;
                    n_count      = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NOKEY;
                end
            end
            F_REP_AT: begin
                if (pos_w >= cnt_w) begin
                    n_status = ST_BADPOS;
                end else begin
                    do_rep = 1'b1;
                end
            end
            F_READ_AT: begin
                if (pos_w >= cnt_w) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_read_value = sel_entry;
                end
            end
            F_SEARCH: begin
                n_found = key_hit;
            end
            F_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // the chain of cells: each takes its neighbor's entry on a shift
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

        t_entry left_entry;
        t_entry right_entry;

        if (i == 0) begin : g_head
            assign left_entry = r_value;
        end else begin : g_left
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_entry = cell_entry[i];
        end else begin : g_right
            assign right_entry = cell_entry[i+1];
        end

        // only entries below the count can match
        assign live_match[i] = cell_match[i] && (IDX < cnt_w);

        assign cell_cmd[i].cmp  = in_accept;
        assign cell_cmd[i].load = exec_go &&
                                  ((do_ins && (IDX == ins_at)) ||
                                   (do_rep && (IDX == pos_w)));
        assign cell_cmd[i].up   = exec_go && do_ins && (IDX > ins_at);
        assign cell_cmd[i].down = exec_go &&
                                  ((do_del_pos && (IDX >= pos_w)) ||
                                   (do_del_key && from_hit[i]));

        oale_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd[i]),
            .i_key   (i_value),
            .i_value (r_value),
            .i_left  (left_entry),
            .i_right (right_entry),
            .o_entry (cell_entry[i]),
            .o_match (cell_match[i])
        );
    end

    // controller: state, count and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken with no new one following it
            if (r_out_valid && i_out_ready && !exec_go) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_state     <= S_IDLE;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        // payload registers
        if (in_accept) begin
            r_func  <= i_func;
            r_pos   <= i_pos;
            r_value <= i_value;
        end
        if (exec_go) begin
            r_out_read_value <= n_read_value;
            r_out_found      <= n_found;
            r_out_status     <= n_status;
            r_out_length     <= LEN_W'(n_count);
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_read_value;
    assign o_found      = r_out_found;
    assign o_status     = r_out_status;
    assign o_length     = r_out_length;

    // count never goes past the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    // an accepted item always moves the controller to execute
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted item did not reach execute");

    // a new result only appears out of the execute cycle
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result raised outside execute");

    // a found key always comes with ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_status == ST_OK))
        else $error("found flag with error status");

endmodule

@@ design/oale_cell.sv @@
// one list cell: holds one entry, shifts with its neighbors, compares to a key
module oale_cell (
    input  logic               i_clk,
    input  oale_pkg::t_cell_cmd i_cmd,
    input  oale_pkg::t_entry   i_key,
    input  oale_pkg::t_entry   i_value,
    input  oale_pkg::t_entry   i_left,
    input  oale_pkg::t_entry   i_right,
    output oale_pkg::t_entry   o_entry,
    output logic               o_match
);
    import oale_pkg::*;

    t_entry r_entry;
    logic   r_match;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_match <= (r_entry == i_key);
        end
        if (i_cmd.load) begin
            r_entry <= i_value;
        end else if (i_cmd.up) begin
            r_entry <= i_left;
        end else if (i_cmd.down) begin
            r_entry <= i_right;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule
